>>> src/sfc_pkg.sv
// Shared constants and types for the Shannon-Fano code builder.
// Used by sfc_front, sfc_queue, sfc_back and the top level.
package sfc_pkg;

    localparam int NUM_SYMBOLS  = 8;
    localparam int FREQ_BITS    = 24;
    localparam int FREQ_IN_BITS = 24;
    localparam int SYM_BITS     = 3;
    localparam int CODE_BITS    = 7;
    localparam int LEN_BITS     = 3;
    localparam int IDX_BITS     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int DEPTH_BITS   = $clog2(NUM_SYMBOLS + 1);
    localparam int SUM_BITS     = FREQ_BITS + IDX_BITS;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [FREQ_BITS-1:0] freq;
        logic [IDX_BITS-1:0]  idx;
        logic                 last;
    } load_item_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] lo;
        logic [IDX_BITS-1:0] hi;
    } range_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_POP,
        ST_RD_A,
        ST_RD_B,
        ST_SPLIT,
        ST_ACC,
        ST_PUSH_HI,
        ST_EMIT
    } back_state_t;

endpackage

>>> src/sfc_front.sv
// Front end: accepts frequency requests, tags each with its slot and set-end mark.
// Depends on sfc_pkg.
module sfc_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sfc_pkg::FREQ_IN_BITS-1:0] frequency,
    output logic                           push_valid,
    input  logic                           push_ready,
    output sfc_pkg::load_item_t            push_item
);

    logic [sfc_pkg::IDX_BITS-1:0] idx_reg;
    logic [sfc_pkg::IDX_BITS-1:0] idx_next;
    logic                         is_last;

    assign is_last    = (idx_reg == sfc_pkg::IDX_BITS'(sfc_pkg::NUM_SYMBOLS - 1));
    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    always_comb
    begin
        push_item.freq = sfc_pkg::FREQ_BITS'(frequency);
        push_item.idx  = idx_reg;
        push_item.last = is_last;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (in_valid && push_ready)
        begin
            idx_next = is_last ? '0 : idx_reg + sfc_pkg::IDX_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

>>> src/sfc_queue.sv
// Short FIFO between front and back end, carrying tagged load requests.
// Depends on sfc_pkg.
module sfc_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  sfc_pkg::load_item_t push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output sfc_pkg::load_item_t pop_item
);

    sfc_pkg::load_item_t           entries_reg [sfc_pkg::QUEUE_DEPTH];
    logic [sfc_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [sfc_pkg::QPTR_BITS-1:0] wr_ptr_next;
    logic [sfc_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [sfc_pkg::QPTR_BITS-1:0] rd_ptr_next;
    logic [sfc_pkg::QCNT_BITS-1:0] count_reg;
    logic [sfc_pkg::QCNT_BITS-1:0] count_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (count_reg != sfc_pkg::QCNT_BITS'(sfc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == sfc_pkg::QPTR_BITS'(sfc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + sfc_pkg::QPTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sfc_pkg::QPTR_BITS'(sfc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + sfc_pkg::QPTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + sfc_pkg::QCNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - sfc_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> src/sfc_back.sv
// Back end: frequency memory, range-stack split sequencer and result emitter.
// Depends on sfc_pkg.
module sfc_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  sfc_pkg::load_item_t            q_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sfc_pkg::SYM_BITS-1:0]   symbol_index,
    output logic [sfc_pkg::CODE_BITS-1:0]  code_bits,
    output logic [sfc_pkg::LEN_BITS-1:0]   code_length,
    output logic                           last_code
);

    localparam int N  = sfc_pkg::NUM_SYMBOLS;
    localparam int IW = sfc_pkg::IDX_BITS;
    localparam int DW = sfc_pkg::DEPTH_BITS;
    localparam int SW = sfc_pkg::SUM_BITS;
    localparam int CW = sfc_pkg::CODE_BITS;
    localparam int LW = sfc_pkg::LEN_BITS;

    sfc_pkg::back_state_t state_reg;
    sfc_pkg::back_state_t state_next;

    logic [sfc_pkg::FREQ_BITS-1:0] freq_mem [N];
    logic [sfc_pkg::FREQ_BITS-1:0] mem_rdata_reg;
    logic                          mem_we;
    logic [IW-1:0]                 mem_raddr;

    sfc_pkg::range_t stack_reg [N];
    sfc_pkg::range_t stack_next [N];
    logic [CW-1:0]   code_reg [N];
    logic [CW-1:0]   code_next [N];
    logic [LW-1:0]   len_reg [N];
    logic [LW-1:0]   len_next [N];

    logic [DW-1:0] depth_reg;
    logic [DW-1:0] depth_next;
    logic [IW-1:0] lo_reg;
    logic [IW-1:0] lo_next;
    logic [IW-1:0] hi_reg;
    logic [IW-1:0] hi_next;
    logic [IW-1:0] a_reg;
    logic [IW-1:0] a_next;
    logic [IW-1:0] b_reg;
    logic [IW-1:0] b_next;
    logic [SW-1:0] asum_reg;
    logic [SW-1:0] asum_next;
    logic [SW-1:0] bsum_reg;
    logic [SW-1:0] bsum_next;
    logic          side_reg;
    logic          side_next;
    logic [IW-1:0] emit_idx_reg;
    logic [IW-1:0] emit_idx_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [sfc_pkg::SYM_BITS-1:0] sym_reg;
    logic [sfc_pkg::SYM_BITS-1:0] sym_next;
    logic [CW-1:0]       out_code_reg;
    logic [CW-1:0]       out_code_next;
    logic [LW-1:0]       out_len_reg;
    logic [LW-1:0]       out_len_next;
    logic                out_last_reg;
    logic                out_last_next;

    sfc_pkg::range_t top_ent;
    logic [DW-1:0]   depth_m1;
    logic            stack_empty;
    logic            stack_room;
    logic            range_ok;
    logic            step_more;
    logic            grow_upper;
    logic            out_load;
    logic            emit_last;

    assign depth_m1    = depth_reg - DW'(1);
    assign top_ent     = stack_reg[depth_m1[IW-1:0]];
    assign stack_empty = (depth_reg == '0);
    assign stack_room  = (depth_reg < DW'(N));
    assign range_ok    = ({1'b0, top_ent.hi} < (IW+1)'(N)) && (top_ent.lo < top_ent.hi);
    assign step_more   = (({1'b0, a_reg} + (IW+1)'(1)) < {1'b0, b_reg});
    assign grow_upper  = (asum_reg >= bsum_reg);
    assign out_load    = !out_valid_reg || out_ready;
    assign emit_last   = (emit_idx_reg == IW'(N - 1));

    assign out_valid    = out_valid_reg;
    assign symbol_index = sym_reg;
    assign code_bits    = out_code_reg;
    assign code_length  = out_len_reg;
    assign last_code    = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfc_pkg::ST_IDLE:
            begin
                if (q_valid && q_item.last)
                begin
                    state_next = sfc_pkg::ST_INIT;
                end
            end
            sfc_pkg::ST_INIT:
            begin
                state_next = sfc_pkg::ST_POP;
            end
            sfc_pkg::ST_POP:
            begin
                if (stack_empty)
                begin
                    state_next = sfc_pkg::ST_EMIT;
                end
                else if (range_ok)
                begin
                    state_next = sfc_pkg::ST_RD_A;
                end
            end
            sfc_pkg::ST_RD_A:
            begin
                state_next = sfc_pkg::ST_RD_B;
            end
            sfc_pkg::ST_RD_B:
            begin
                state_next = sfc_pkg::ST_SPLIT;
            end
            sfc_pkg::ST_SPLIT:
            begin
                state_next = step_more ? sfc_pkg::ST_ACC : sfc_pkg::ST_PUSH_HI;
            end
            sfc_pkg::ST_ACC:
            begin
                state_next = sfc_pkg::ST_SPLIT;
            end
            sfc_pkg::ST_PUSH_HI:
            begin
                state_next = sfc_pkg::ST_POP;
            end
            sfc_pkg::ST_EMIT:
            begin
                if (out_load && emit_last)
                begin
                    state_next = sfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sfc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_ready        = 1'b0;
        mem_we         = 1'b0;
        mem_raddr      = a_reg;
        stack_next     = stack_reg;
        code_next      = code_reg;
        len_next       = len_reg;
        depth_next     = depth_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        asum_next      = asum_reg;
        bsum_next      = bsum_reg;
        side_next      = side_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sym_next       = sym_reg;
        out_code_next  = out_code_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            sfc_pkg::ST_IDLE:
            begin
                q_ready = 1'b1;
                mem_we  = q_valid;
            end
            sfc_pkg::ST_INIT:
            begin
                for (int k = 0; k < N; k++)
                begin
                    code_next[k] = '0;
                    len_next[k]  = '0;
                end
                stack_next[0].lo = '0;
                stack_next[0].hi = IW'(N - 1);
                depth_next       = DW'(1);
                emit_idx_next    = '0;
            end
            sfc_pkg::ST_POP:
            begin
                if (!stack_empty)
                begin
                    depth_next = depth_m1;
                    lo_next    = top_ent.lo;
                    hi_next    = top_ent.hi;
                    a_next     = top_ent.lo;
                    b_next     = top_ent.hi;
                    mem_raddr  = top_ent.lo;
                end
            end
            sfc_pkg::ST_RD_A:
            begin
                asum_next = SW'(mem_rdata_reg);
                mem_raddr = b_reg;
            end
            sfc_pkg::ST_RD_B:
            begin
                bsum_next = SW'(mem_rdata_reg);
            end
            sfc_pkg::ST_SPLIT:
            begin
                if (step_more)
                begin
                    if (grow_upper)
                    begin
                        b_next    = b_reg - IW'(1);
                        mem_raddr = b_reg - IW'(1);
                        side_next = 1'b1;
                    end
                    else
                    begin
                        a_next    = a_reg + IW'(1);
                        mem_raddr = a_reg + IW'(1);
                        side_next = 1'b0;
                    end
                end
                else
                begin
                    for (int k = 0; k < N; k++)
                    begin
                        if ((IW'(k) >= lo_reg) && (IW'(k) <= a_reg))
                        begin
                            code_next[k] = {code_reg[k][CW-2:0], 1'b0};
                            len_next[k]  = len_reg[k] + LW'(1);
                        end
                        else if ((IW'(k) >= b_reg) && (IW'(k) <= hi_reg))
                        begin
                            code_next[k] = {code_reg[k][CW-2:0], 1'b1};
                            len_next[k]  = len_reg[k] + LW'(1);
                        end
                    end
                    if ((a_reg > lo_reg) && stack_room)
                    begin
                        stack_next[depth_reg[IW-1:0]].lo = lo_reg;
                        stack_next[depth_reg[IW-1:0]].hi = a_reg;
                        depth_next = depth_reg + DW'(1);
                    end
                end
            end
            sfc_pkg::ST_ACC:
            begin
                if (side_reg)
                begin
                    bsum_next = bsum_reg + SW'(mem_rdata_reg);
                end
                else
                begin
                    asum_next = asum_reg + SW'(mem_rdata_reg);
                end
            end
            sfc_pkg::ST_PUSH_HI:
            begin
                if ((hi_reg > b_reg) && stack_room)
                begin
                    stack_next[depth_reg[IW-1:0]].lo = b_reg;
                    stack_next[depth_reg[IW-1:0]].hi = hi_reg;
                    depth_next = depth_reg + DW'(1);
                end
            end
            sfc_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    sym_next       = sfc_pkg::SYM_BITS'(emit_idx_reg);
                    out_code_next  = code_reg[emit_idx_reg];
                    out_len_next   = len_reg[emit_idx_reg];
                    out_last_next  = emit_last;
                    emit_idx_next  = emit_last ? '0 : emit_idx_reg + IW'(1);
                end
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfc_pkg::ST_IDLE;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
            emit_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            emit_idx_reg  <= emit_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stack_reg    <= stack_next;
        code_reg     <= code_next;
        len_reg      <= len_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        asum_reg     <= asum_next;
        bsum_reg     <= bsum_next;
        side_reg     <= side_next;
        sym_reg      <= sym_next;
        out_code_reg <= out_code_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            freq_mem[q_item.idx] <= q_item.freq;
        end
        mem_rdata_reg <= freq_mem[mem_raddr];
    end

endmodule

>>> src/shannon_fano_code_builder.sv
// Top level of the Shannon-Fano code builder: front end, request queue, back end.
// Depends on sfc_pkg, sfc_front, sfc_queue and sfc_back.
//
// Input channel (in_valid/in_ready/frequency): one request per symbol, eight
// per set, in descending frequency order. A request is parked in a two-entry
// queue; while idle, the back end stores one frequency per cycle.
// After the eighth request the back end builds the code on one frequency
// memory read port: each split pops a range, reads its two end frequencies,
// grows the lighter side (the upper side on a tie) one entry at a time until
// the sides meet, then pushes each half of more than one entry. Requests of
// the next set queue up meanwhile; in_ready drops once the queue is full.
// Output channel (out_valid/out_ready): eight results, symbol 0 first, one per
// cycle while the receiver is ready, from an output register; last_code marks
// symbol 7. A stalled receiver holds the result and the back end waits; the
// final result of a set may wait while the next set loads.
// Reset clears the load position, the queue, the range stack and the output
// valid; frequencies left from an earlier set are not used.
module shannon_fano_code_builder
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sfc_pkg::FREQ_IN_BITS-1:0] frequency,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sfc_pkg::SYM_BITS-1:0]     symbol_index,
    output logic [sfc_pkg::CODE_BITS-1:0]    code_bits,
    output logic [sfc_pkg::LEN_BITS-1:0]     code_length,
    output logic                             last_code
);

    logic                push_valid;
    logic                push_ready;
    sfc_pkg::load_item_t push_item;
    logic                pop_valid;
    logic                pop_ready;
    sfc_pkg::load_item_t pop_item;

    sfc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frequency  (frequency),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    sfc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    sfc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (pop_valid),
        .q_ready      (pop_ready),
        .q_item       (pop_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .symbol_index (symbol_index),
        .code_bits    (code_bits),
        .code_length  (code_length),
        .last_code    (last_code)
    );

    a_last_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
        (last_code == (symbol_index == sfc_pkg::SYM_BITS'(sfc_pkg::NUM_SYMBOLS - 1))))
        else $error("last_code does not match final symbol");

    a_gap_after_set: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_code) |=> !out_valid)
        else $error("result presented right after end of set");

    a_symbols_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_code) |=>
        (out_valid &&
         (symbol_index == sfc_pkg::SYM_BITS'($past(symbol_index) + sfc_pkg::SYM_BITS'(1)))))
        else $error("results out of symbol order");

endmodule
